// ===== design/assert_macros.svh =====
// Assertion macros shared by the resize core RTL.
// Included by every file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== design/brir_pkg.sv =====
// Shared types and constants for the bilinear resize core.
// No dependencies; imported by brir_coord, brir_interp and bilinear_image_resize_core.
package brir_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_X        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_Y        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS      = 3'd4;

   localparam logic [8:0]  RST_SOURCE_WIDTH  = 9'd256;
   localparam logic [8:0]  RST_SOURCE_HEIGHT = 9'd256;
   localparam logic [23:0] RST_STEP          = 24'd65280;
   localparam logic [1:0]  RST_CHANNELS      = 2'd1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] row;
      logic [7:0] col;
      logic [1:0] channel;
      logic [7:0] pixel_in;
   } brir_req_type;

   typedef struct packed {
      logic       chan_ok;
      logic [7:0] row;
      logic [7:0] col;
      logic [1:0] channel;
   } brir_tag_type;

endpackage

// ===== design/brir_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies; used for the four parity banks of the source store.
module brir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/brir_coord.sv =====
// Coordinate stages: input register, step multiply, integer clamp and range check.
// Depends on brir_pkg and assert_macros.svh.
`include "assert_macros.svh"
module brir_coord import brir_pkg::*; #(
   parameter int XW = 8,
   parameter int YW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  brir_req_type  in_req,
   input  logic [23:0]   step_x,
   input  logic [23:0]   step_y,
   input  logic [XW-1:0] wm1,
   input  logic [YW-1:0] hm1,
   input  logic [2:0]    nch,
   output logic          out_valid,
   output brir_req_type  out_req,
   output logic          out_chan_ok,
   output logic          out_load_ok,
   output logic [XW-1:0] out_x0,
   output logic [XW-1:0] out_x1,
   output logic [YW-1:0] out_y0,
   output logic [YW-1:0] out_y1,
   output logic [15:0]   out_fx,
   output logic [15:0]   out_fy
);

   logic         p1_valid_ff;
   brir_req_type p1_req_ff;

   logic         p2_valid_ff;
   brir_req_type p2_req_ff;
   logic         p2_chan_ok_ff;
   logic [31:0]  p2_sx_ff;
   logic [31:0]  p2_sy_ff;
   logic [31:0]  p2_sx_in;
   logic [31:0]  p2_sy_in;
   logic         p2_chan_ok_in;

   logic          p3_valid_ff;
   brir_req_type  p3_req_ff;
   logic          p3_chan_ok_ff;
   logic          p3_load_ok_ff;
   logic [XW-1:0] p3_x0_ff;
   logic [XW-1:0] p3_x1_ff;
   logic [YW-1:0] p3_y0_ff;
   logic [YW-1:0] p3_y1_ff;
   logic [15:0]   p3_fx_ff;
   logic [15:0]   p3_fy_ff;

   logic [15:0]   ix;
   logic [15:0]   iy;
   logic [XW-1:0] x0c;
   logic [XW-1:0] x1c;
   logic [YW-1:0] y0c;
   logic [YW-1:0] y1c;
   logic [XW-1:0] p3_x0_in;
   logic [XW-1:0] p3_x1_in;
   logic [YW-1:0] p3_y0_in;
   logic [YW-1:0] p3_y1_in;
   logic          p3_load_ok_in;

   assign p2_sx_in      = {24'd0, p1_req_ff.col} * {8'd0, step_x};
   assign p2_sy_in      = {24'd0, p1_req_ff.row} * {8'd0, step_y};
   assign p2_chan_ok_in = ({1'b0, p1_req_ff.channel} < nch);

   assign ix  = p2_sx_ff[31:16];
   assign iy  = p2_sy_ff[31:16];
   assign x0c = (ix >= 16'(wm1)) ? wm1 : ix[XW-1:0];
   assign y0c = (iy >= 16'(hm1)) ? hm1 : iy[YW-1:0];
   assign x1c = (x0c == wm1) ? x0c : x0c + XW'(1);
   assign y1c = (y0c == hm1) ? y0c : y0c + YW'(1);

   always_comb begin
      if (p2_req_ff.command == CMD_LOAD) begin
         p3_x0_in = XW'(p2_req_ff.col);
         p3_x1_in = XW'(p2_req_ff.col);
         p3_y0_in = YW'(p2_req_ff.row);
         p3_y1_in = YW'(p2_req_ff.row);
      end else begin
         p3_x0_in = x0c;
         p3_x1_in = x1c;
         p3_y0_in = y0c;
         p3_y1_in = y1c;
      end
      p3_load_ok_in = (p2_req_ff.command == CMD_LOAD)
                   && (16'(p2_req_ff.col) <= 16'(wm1))
                   && (16'(p2_req_ff.row) <= 16'(hm1))
                   && p2_chan_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_req_ff     <= in_req;
         p2_req_ff     <= p1_req_ff;
         p2_chan_ok_ff <= p2_chan_ok_in;
         p2_sx_ff      <= p2_sx_in;
         p2_sy_ff      <= p2_sy_in;
         p3_req_ff     <= p2_req_ff;
         p3_chan_ok_ff <= p2_chan_ok_ff;
         p3_load_ok_ff <= p3_load_ok_in;
         p3_x0_ff      <= p3_x0_in;
         p3_x1_ff      <= p3_x1_in;
         p3_y0_ff      <= p3_y0_in;
         p3_y1_ff      <= p3_y1_in;
         p3_fx_ff      <= p2_sx_ff[15:0];
         p3_fy_ff      <= p2_sy_ff[15:0];
      end
   end

   assign out_valid   = p3_valid_ff;
   assign out_req     = p3_req_ff;
   assign out_chan_ok = p3_chan_ok_ff;
   assign out_load_ok = p3_load_ok_ff;
   assign out_x0      = p3_x0_ff;
   assign out_x1      = p3_x1_ff;
   assign out_y0      = p3_y0_ff;
   assign out_y1      = p3_y1_ff;
   assign out_fx      = p3_fx_ff;
   assign out_fy      = p3_fy_ff;

   `ASSERT_PROP(a_neighbors_in_image, clock, reset, (p3_valid_ff && p3_req_ff.command == CMD_COMPUTE) |-> (p3_x1_ff <= wm1 && p3_y1_ff <= hm1 && (p3_x1_ff == p3_x0_ff || p3_x1_ff == p3_x0_ff + XW'(1))), "neighbor column or row outside clamped image")

endmodule

// ===== design/brir_interp.sv =====
// Blend stages: horizontal weighting of both neighbor rows, then vertical weighting.
// Depends on brir_pkg.
module brir_interp import brir_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  brir_tag_type in_tag,
   input  logic [15:0]  in_fx,
   input  logic [15:0]  in_fy,
   input  logic [7:0]   in_p00,
   input  logic [7:0]   in_p01,
   input  logic [7:0]   in_p10,
   input  logic [7:0]   in_p11,
   output logic         out_valid,
   output brir_tag_type out_tag,
   output logic [7:0]   out_pixel
);

   logic [16:0]  gx;
   logic [24:0]  h0_in;
   logic [24:0]  h1_in;

   logic         p5_valid_ff;
   brir_tag_type p5_tag_ff;
   logic [15:0]  p5_fy_ff;
   logic [24:0]  p5_h0_ff;
   logic [24:0]  p5_h1_ff;

   logic [16:0]  gy;
   logic [40:0]  acc;
   logic [7:0]   pix_in;

   logic         p6_valid_ff;
   brir_tag_type p6_tag_ff;
   logic [7:0]   p6_pix_ff;

   assign gx    = 17'h10000 - {1'b0, in_fx};
   assign h0_in = {8'd0, gx} * {17'd0, in_p00} + {9'd0, in_fx} * {17'd0, in_p01};
   assign h1_in = {8'd0, gx} * {17'd0, in_p10} + {9'd0, in_fx} * {17'd0, in_p11};

   assign gy     = 17'h10000 - {1'b0, p5_fy_ff};
   assign acc    = {24'd0, gy} * {16'd0, p5_h0_ff} + {25'd0, p5_fy_ff} * {16'd0, p5_h1_ff};
   assign pix_in = p5_tag_ff.chan_ok ? acc[39:32] : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
      end else if (en) begin
         p5_valid_ff <= in_valid;
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p5_tag_ff <= in_tag;
         p5_fy_ff  <= in_fy;
         p5_h0_ff  <= h0_in;
         p5_h1_ff  <= h1_in;
         p6_tag_ff <= p5_tag_ff;
         p6_pix_ff <= pix_in;
      end
   end

   assign out_valid = p6_valid_ff;
   assign out_tag   = p6_tag_ff;
   assign out_pixel = p6_pix_ff;

endmodule

// ===== design/bilinear_image_resize_core.sv =====
// Bilinear resize core: source pixel store in four row/column parity banks plus blend pipeline.
// Pipeline: a compute transaction passes the input, multiply, clamp, bank read, horizontal blend
// and vertical blend stages and the output register to reach rsp_tvalid; loads give no output.
// Throughput: one transaction per cycle while req_tready is high; one read gets all neighbors.
// Reset: clears pipeline valids and restores register defaults; the pixel store is not cleared.
`include "assert_macros.svh"
module bilinear_image_resize_core import brir_pkg::*; #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int MAX_CHANNELS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // row, col, channel, pixel_in, zero pad
   input  logic                   req_tuser,   // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // pixel_out, out_row, out_col, out_channel, pad
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_H * HALF_W * MAX_CHANNELS;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [8:0]  source_width_ff;
   logic [8:0]  source_height_ff;
   logic [23:0] step_x_ff;
   logic [23:0] step_y_ff;
   logic [1:0]  channels_ff;

   logic [XW-1:0] wm1;
   logic [YW-1:0] hm1;
   logic [2:0]    nch;

   logic         en;
   brir_req_type in_req;

   logic          c_valid;
   brir_req_type  c_req;
   logic          c_chan_ok;
   logic          c_load_ok;
   logic [XW-1:0] c_x0;
   logic [XW-1:0] c_x1;
   logic [YW-1:0] c_y0;
   logic [YW-1:0] c_y1;
   logic [15:0]   c_fx;
   logic [15:0]   c_fy;

   logic [3:0]  bank_we;
   logic [7:0]  bank_q [4];

   logic         p4_valid_ff;
   brir_tag_type p4_tag_ff;
   logic [15:0]  p4_fx_ff;
   logic [15:0]  p4_fy_ff;
   logic         p4_y0p_ff;
   logic         p4_x0p_ff;
   logic         p4_y1p_ff;
   logic         p4_x1p_ff;
   logic         p4_valid_in;
   brir_tag_type p4_tag_in;

   logic         fin_valid;
   brir_tag_type fin_tag;
   logic [7:0]   fin_pix;

   logic         rsp_valid_ff;
   brir_tag_type rsp_tag_ff;
   logic [7:0]   rsp_pix_ff;
   logic         skid_valid_ff;
   brir_tag_type skid_tag_ff;
   logic [7:0]   skid_pix_ff;
   logic         rsp_valid_in;
   brir_tag_type rsp_tag_in;
   logic [7:0]   rsp_pix_in;
   logic         skid_valid_in;
   brir_tag_type skid_tag_in;
   logic [7:0]   skid_pix_in;
   logic         out_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= RST_SOURCE_WIDTH;
         source_height_ff <= RST_SOURCE_HEIGHT;
         step_x_ff        <= RST_STEP;
         step_y_ff        <= RST_STEP;
         channels_ff      <= RST_CHANNELS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_wdata[8:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_wdata[8:0];
            CSR_STEP_X:        step_x_ff        <= csr_wdata[23:0];
            CSR_STEP_Y:        step_y_ff        <= csr_wdata[23:0];
            CSR_CHANNELS:      channels_ff      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (source_width_ff < 9'd2) begin
         wm1 = XW'(1);
      end else if (13'(source_width_ff) > 13'(MAX_WIDTH)) begin
         wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         wm1 = XW'(source_width_ff - 9'd1);
      end
      if (source_height_ff < 9'd2) begin
         hm1 = YW'(1);
      end else if (13'(source_height_ff) > 13'(MAX_HEIGHT)) begin
         hm1 = YW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = YW'(source_height_ff - 9'd1);
      end
      if (channels_ff == 2'd0) begin
         nch = 3'd1;
      end else if (3'(channels_ff) > 3'(MAX_CHANNELS)) begin
         nch = 3'(MAX_CHANNELS);
      end else begin
         nch = 3'(channels_ff);
      end
   end

   // advance the whole pipeline unless the skid stage is holding a result
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign in_req.command  = req_tuser;
   assign in_req.row      = req_tdata[7:0];
   assign in_req.col      = req_tdata[15:8];
   assign in_req.channel  = req_tdata[17:16];
   assign in_req.pixel_in = req_tdata[25:18];

   brir_coord #(.XW(XW), .YW(YW)) u_coord (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .in_req      (in_req),
      .step_x      (step_x_ff),
      .step_y      (step_y_ff),
      .wm1         (wm1),
      .hm1         (hm1),
      .nch         (nch),
      .out_valid   (c_valid),
      .out_req     (c_req),
      .out_chan_ok (c_chan_ok),
      .out_load_ok (c_load_ok),
      .out_x0      (c_x0),
      .out_x1      (c_x1),
      .out_y0      (c_y0),
      .out_y1      (c_y1),
      .out_fx      (c_fx),
      .out_fy      (c_fy)
   );

   for (genvar gr = 0; gr < 2; gr++) begin : g_row
      for (genvar gc = 0; gc < 2; gc++) begin : g_col
         logic [YW-1:0] yh;
         logic [XW-1:0] xh;
         logic [AW-1:0] addr;

         assign yh   = (c_y0[0] == 1'(gr)) ? (c_y0 >> 1) : (c_y1 >> 1);
         assign xh   = (c_x0[0] == 1'(gc)) ? (c_x0 >> 1) : (c_x1 >> 1);
         assign addr = (AW'(yh) * AW'(HALF_W) + AW'(xh)) * AW'(MAX_CHANNELS)
                     + AW'(c_req.channel);
         assign bank_we[gr*2+gc] = en && c_valid && c_load_ok
                                && (c_y0[0] == 1'(gr)) && (c_x0[0] == 1'(gc));

         brir_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
            .clock   (clock),
            .wr_en   (bank_we[gr*2+gc]),
            .wr_addr (addr),
            .wr_data (c_req.pixel_in),
            .rd_en   (en),
            .rd_addr (addr),
            .rd_data (bank_q[gr*2+gc])
         );
      end
   end

   assign p4_valid_in       = c_valid && (c_req.command == CMD_COMPUTE);
   assign p4_tag_in.chan_ok = c_chan_ok;
   assign p4_tag_in.row     = c_req.row;
   assign p4_tag_in.col     = c_req.col;
   assign p4_tag_in.channel = c_req.channel;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p4_valid_ff <= p4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_tag_ff <= p4_tag_in;
         p4_fx_ff  <= c_fx;
         p4_fy_ff  <= c_fy;
         p4_y0p_ff <= c_y0[0];
         p4_x0p_ff <= c_x0[0];
         p4_y1p_ff <= c_y1[0];
         p4_x1p_ff <= c_x1[0];
      end
   end

   brir_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p4_valid_ff),
      .in_tag    (p4_tag_ff),
      .in_fx     (p4_fx_ff),
      .in_fy     (p4_fy_ff),
      .in_p00    (bank_q[{p4_y0p_ff, p4_x0p_ff}]),
      .in_p01    (bank_q[{p4_y0p_ff, p4_x1p_ff}]),
      .in_p10    (bank_q[{p4_y1p_ff, p4_x0p_ff}]),
      .in_p11    (bank_q[{p4_y1p_ff, p4_x1p_ff}]),
      .out_valid (fin_valid),
      .out_tag   (fin_tag),
      .out_pixel (fin_pix)
   );

   // output register with one skid entry behind it
   assign out_take = rsp_valid_ff && rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pix_in    = rsp_pix_ff;
      skid_valid_in = skid_valid_ff;
      skid_tag_in   = skid_tag_ff;
      skid_pix_in   = skid_pix_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_tag_in    = skid_tag_ff;
            rsp_pix_in    = skid_pix_ff;
            skid_valid_in = 1'b0;
         end
      end else if (fin_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_tag_in   = fin_tag;
            rsp_pix_in   = fin_pix;
         end else begin
            skid_valid_in = 1'b1;
            skid_tag_in   = fin_tag;
            skid_pix_in   = fin_pix;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff  <= rsp_tag_in;
      rsp_pix_ff  <= rsp_pix_in;
      skid_tag_ff <= skid_tag_in;
      skid_pix_ff <= skid_pix_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_tag_ff.channel, rsp_tag_ff.col, rsp_tag_ff.row, rsp_pix_ff};

   `ASSERT_NEVER(a_skid_needs_rsp, clock, reset, skid_valid_ff && !rsp_valid_ff, "skid entry held while output register is empty")
   `ASSERT_PROP(a_skid_holds, clock, reset, (skid_valid_ff && !rsp_tready) |=> (skid_valid_ff && $stable(skid_pix_ff) && $stable(skid_tag_ff)), "skid entry lost or changed during stall")
   `ASSERT_PROP(a_one_bank_write, clock, reset, $onehot0(bank_we), "more than one bank written in a cycle")

endmodule
